/* hdl/mphq_pkg.sv */
// shared types and constants of the max-priority heap queue
`timescale 1ns / 1ps

package mphq_pkg;

    localparam int MAX_ENTRIES = 64;
    localparam int ADDR_W      = $clog2(MAX_ENTRIES);
    localparam int CNT_W       = ADDR_W + 1;

    localparam int PRIO_W   = 16;
    localparam int PAY_W    = 16;
    localparam int ENTRY_W  = PRIO_W + PAY_W;
    localparam int CAP_W    = 7;
    localparam int COUNT_W  = 7;
    localparam int STATUS_W = 2;
    localparam int CMP_W    = (CNT_W > CAP_W) ? CNT_W : CAP_W;

    localparam int IN_DATA_W  = 32;
    localparam int OUT_DATA_W = 40;
    localparam int OUT_PAD_W  = OUT_DATA_W - PRIO_W - PAY_W - COUNT_W;

    localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_REMOVE = 1'b1;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

    typedef struct packed {
        logic [PRIO_W-1:0] prio;
        logic [PAY_W-1:0]  pay;
    } entry_t;

endpackage

/* hdl/mphq_ram.sv */
// generic ram: one write port, two registered read ports
`timescale 1ns / 1ps

module mphq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr_a,
    input  logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic [WIDTH-1:0]         rdata_a,
    output logic [WIDTH-1:0]         rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end

endmodule

/* hdl/max_priority_heap_queue.sv */
// binary max-heap priority queue: top level with sequencer and heap ram
//
// usage
//   s_* channel takes one item: s_tuser is the operation (0 insert, 1 remove max),
//   s_tdata carries the priority and payload of an insert (ignored on remove)
//   m_* channel returns one item per input item: status in m_tuser, removed
//   priority, payload and the entry count after the operation in m_tdata
//   cfg_* channel writes the capacity limit (1..64, above 64 acts as 64);
//   write it only while the block is idle
// rate
//   one item at a time; s_tready is high only while the sequencer is idle
//   each heap level takes one read of the shared ram (parent, or
//   both children on the two read ports) and then one compare and write-back;
//   six levels of sift-up (slot 63 to the root) set the insert worst case,
//   five levels of sift-down set the remove worst case
// reset
//   rst_n clears the fill count, drops any pending result and sets the
//   capacity to 64; the heap ram is not cleared, only live entries are read
// stall
//   the result waits in the output register; the next item can be taken
//   meanwhile, and its sequence holds in the final state until the output
//   register is free
`timescale 1ns / 1ps

module max_priority_heap_queue (
    input  logic                             clk,
    input  logic                             rst_n,
    // input items
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [mphq_pkg::IN_DATA_W-1:0]   s_tdata,  // priority_req[15:0], payload[31:16]
    input  logic                             s_tuser,  // op[0]
    // result items
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [mphq_pkg::OUT_DATA_W-1:0]  m_tdata,  // out_priority[15:0], out_payload[31:16],
                                                       // entry_count[38:32], zero[39]
    output logic [mphq_pkg::STATUS_W-1:0]    m_tuser,  // status[1:0]
    // capacity register write
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [mphq_pkg::CAP_W-1:0]       cfg_data
);

    localparam int AW = mphq_pkg::ADDR_W;
    localparam int CW = mphq_pkg::CNT_W;

    // sequencer states
    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_START    = 3'd1;
    localparam logic [2:0] S_UP_ISSUE = 3'd2;
    localparam logic [2:0] S_UP_CMP   = 3'd3;
    localparam logic [2:0] S_RM_LOAD  = 3'd4;
    localparam logic [2:0] S_DN_ISSUE = 3'd5;
    localparam logic [2:0] S_DN_CMP   = 3'd6;
    localparam logic [2:0] S_FIN      = 3'd7;

    // control state
    logic [2:0]                   state_reg, state_next;
    logic [CW-1:0]                fill_reg, fill_next;
    logic [mphq_pkg::CAP_W-1:0]   cap_reg, cap_next;
    logic                         m_valid_reg, m_valid_next;

    // working registers of the current item
    logic                         op_reg, op_next;
    mphq_pkg::entry_t             cur_reg, cur_next;       // entry being sifted
    logic [AW-1:0]                hole_reg, hole_next;     // slot it currently owns
    logic [AW-1:0]                left_idx_reg, left_idx_next;
    logic                         right_ok_reg, right_ok_next;
    logic [mphq_pkg::STATUS_W-1:0] status_reg, status_next;
    mphq_pkg::entry_t             res_reg, res_next;       // removed maximum or zero

    // output register
    logic [mphq_pkg::OUT_DATA_W-1:0] m_tdata_reg, m_tdata_next;
    logic [mphq_pkg::STATUS_W-1:0]   m_tuser_reg, m_tuser_next;

    // heap ram ports
    logic                         ram_we;
    logic [AW-1:0]                ram_waddr;
    mphq_pkg::entry_t             ram_wdata;
    logic [AW-1:0]                ram_raddr_a, ram_raddr_b;
    logic [mphq_pkg::ENTRY_W-1:0] ram_rdata_a, ram_rdata_b;
    mphq_pkg::entry_t             rd_a, rd_b;

    // index arithmetic
    logic [AW-1:0]                parent_idx;
    logic [CW-1:0]                left_w, right_w;
    logic                         heap_full;
    logic                         take_right;
    mphq_pkg::entry_t             child;
    logic [AW-1:0]                child_idx;
    logic                         out_free;

    assign rd_a = mphq_pkg::entry_t'(ram_rdata_a);
    assign rd_b = mphq_pkg::entry_t'(ram_rdata_b);

    assign parent_idx = AW'((hole_reg - AW'(1)) >> 1);
    assign left_w     = {hole_reg, 1'b1};
    assign right_w    = left_w + CW'(1);

    // limit is min(capacity, MAX_ENTRIES)
    assign heap_full = (mphq_pkg::CMP_W'(fill_reg) >= mphq_pkg::CMP_W'(cap_reg))
                    || (fill_reg >= CW'(mphq_pkg::MAX_ENTRIES));

    // larger child, ties to the left
    assign take_right = right_ok_reg && (rd_a.prio < rd_b.prio);
    assign child      = take_right ? rd_b : rd_a;
    assign child_idx  = take_right ? (left_idx_reg + AW'(1)) : left_idx_reg;

    assign out_free  = !m_valid_reg || m_tready;

    assign s_tready  = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = m_tdata_reg;
    assign m_tuser   = m_tuser_reg;

    always_comb
    begin
        state_next    = state_reg;
        fill_next     = fill_reg;
        cap_next      = cap_reg;
        m_valid_next  = m_valid_reg;
        op_next       = op_reg;
        cur_next      = cur_reg;
        hole_next     = hole_reg;
        left_idx_next = left_idx_reg;
        right_ok_next = right_ok_reg;
        status_next   = status_reg;
        res_next      = res_reg;
        m_tdata_next  = m_tdata_reg;
        m_tuser_next  = m_tuser_reg;
        ram_we        = 1'b0;
        ram_waddr     = hole_reg;
        ram_wdata     = cur_reg;
        ram_raddr_a   = parent_idx;
        ram_raddr_b   = parent_idx;

        if (cfg_valid && cfg_ready)
        begin
            cap_next = cfg_data;
        end

        // result taken
        if (m_valid_reg && m_tready)
        begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    op_next       = s_tuser;
                    cur_next.prio = s_tdata[mphq_pkg::PRIO_W-1:0];
                    cur_next.pay  = s_tdata[mphq_pkg::PRIO_W +: mphq_pkg::PAY_W];
                    state_next    = S_START;
                end
            end

            S_START:
            begin
                status_next = mphq_pkg::ST_OK;
                res_next    = '0;
                if (op_reg == mphq_pkg::OP_INSERT)
                begin
                    if (heap_full)
                    begin
                        status_next = mphq_pkg::ST_FULL;
                        state_next  = S_FIN;
                    end
                    else
                    begin
                        hole_next  = AW'(fill_reg);
                        fill_next  = fill_reg + CW'(1);
                        state_next = S_UP_ISSUE;
                    end
                end
                else
                begin
                    if (fill_reg == '0)
                    begin
                        status_next = mphq_pkg::ST_EMPTY;
                        state_next  = S_FIN;
                    end
                    else
                    begin
                        // read root and last entry together
                        fill_next   = fill_reg - CW'(1);
                        ram_raddr_a = '0;
                        ram_raddr_b = AW'(fill_reg - CW'(1));
                        state_next  = S_RM_LOAD;
                    end
                end
            end

            S_UP_ISSUE:
            begin
                if (hole_reg == '0)
                begin
                    ram_we     = 1'b1;
                    state_next = S_FIN;
                end
                else
                begin
                    ram_raddr_a = parent_idx;
                    state_next  = S_UP_CMP;
                end
            end

            S_UP_CMP:
            begin
                ram_we = 1'b1;
                if (rd_a.prio < cur_reg.prio)
                begin
                    // parent moves down into the hole
                    ram_wdata  = rd_a;
                    hole_next  = parent_idx;
                    state_next = S_UP_ISSUE;
                end
                else
                begin
                    state_next = S_FIN;
                end
            end

            S_RM_LOAD:
            begin
                res_next   = rd_a;
                cur_next   = rd_b;
                hole_next  = '0;
                state_next = S_DN_ISSUE;
            end

            S_DN_ISSUE:
            begin
                if (left_w >= fill_reg)
                begin
                    ram_we     = 1'b1;
                    state_next = S_FIN;
                end
                else
                begin
                    ram_raddr_a   = left_w[AW-1:0];
                    ram_raddr_b   = right_w[AW-1:0];
                    left_idx_next = left_w[AW-1:0];
                    right_ok_next = (right_w < fill_reg);
                    state_next    = S_DN_CMP;
                end
            end

            S_DN_CMP:
            begin
                ram_we = 1'b1;
                if (cur_reg.prio < child.prio)
                begin
                    // larger child moves up into the hole
                    ram_wdata  = child;
                    hole_next  = child_idx;
                    state_next = S_DN_ISSUE;
                end
                else
                begin
                    state_next = S_FIN;
                end
            end

            S_FIN:
            begin
                if (out_free)
                begin
                    m_valid_next = 1'b1;
                    m_tuser_next = status_reg;
                    m_tdata_next = {{mphq_pkg::OUT_PAD_W{1'b0}},
                                    mphq_pkg::COUNT_W'(fill_reg),
                                    res_reg.pay, res_reg.prio};
                    state_next   = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            fill_reg    <= '0;
            cap_reg     <= mphq_pkg::CAP_RESET;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            fill_reg    <= fill_next;
            cap_reg     <= cap_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        op_reg       <= op_next;
        cur_reg      <= cur_next;
        hole_reg     <= hole_next;
        left_idx_reg <= left_idx_next;
        right_ok_reg <= right_ok_next;
        status_reg   <= status_next;
        res_reg      <= res_next;
        m_tdata_reg  <= m_tdata_next;
        m_tuser_reg  <= m_tuser_next;
    end

    mphq_ram #(
        .WIDTH (mphq_pkg::ENTRY_W),
        .DEPTH (mphq_pkg::MAX_ENTRIES)
    ) u_heap_ram (
        .clk     (clk),
        .we      (ram_we),
        .waddr   (ram_waddr),
        .wdata   (ram_wdata),
        .raddr_a (ram_raddr_a),
        .raddr_b (ram_raddr_b),
        .rdata_a (ram_rdata_a),
        .rdata_b (ram_rdata_b)
    );

endmodule

/* hdl/mphq_checker.sv */
// port-level checks of the heap queue, bound to the top level
`timescale 1ns / 1ps

module mphq_checker (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             s_tvalid,
    input logic                             s_tready,
    input logic                             m_tvalid,
    input logic                             m_tready,
    input logic [mphq_pkg::OUT_DATA_W-1:0]  m_tdata,
    input logic [mphq_pkg::STATUS_W-1:0]    m_tuser
);

    localparam int DW = mphq_pkg::PRIO_W + mphq_pkg::PAY_W;
    localparam int CL = mphq_pkg::PRIO_W + mphq_pkg::PAY_W;

    // stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // one item in work at a time
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken while an item is in work");

    // refused operations return no entry
    a_refused_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser != mphq_pkg::ST_OK) |-> (m_tdata[DW-1:0] == '0))
        else $error("refused operation returned an entry");

    // remove refused only when the heap shows empty
    a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser == mphq_pkg::ST_EMPTY)
        |-> (m_tdata[CL +: mphq_pkg::COUNT_W] == '0))
        else $error("empty refusal with nonzero count");

endmodule

bind max_priority_heap_queue mphq_checker u_mphq_checker (.*);
